>>> sv/assert_macros.svh
// Assertion macros for the decoder modules; movdec_queue is the one that uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MOVDEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define MOVDEC_NEVER(lbl, cond, msg) \
    `MOVDEC_ASSERT(lbl, !(cond), msg)

`endif

>>> sv/movdec_pkg.sv
// Types, codes and constants of the 8086 MOV byte decoder.
// No dependencies; used by every module of the decoder.
package movdec_pkg;

    typedef enum logic [3:0] {
        PH_OPCODE  = 4'd0,
        PH_MODRM   = 4'd1,
        PH_DISP_LO = 4'd2,
        PH_DISP_HI = 4'd3,
        PH_ADDR_LO = 4'd4,
        PH_ADDR_HI = 4'd5,
        PH_IMM_LO  = 4'd6,
        PH_IMM_HI  = 4'd7
    } phase_t;

    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_RM  = 3'd1,
        FORM_IMM_REG = 3'd2,
        FORM_MEM_ACC = 3'd3,
        FORM_ACC_MEM = 3'd4
    } form_t;

    typedef enum logic [1:0] {
        KIND_REG = 2'd0,
        KIND_EA  = 2'd1,
        KIND_DIR = 2'd2,
        KIND_IMM = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_OP = 2'd1,
        ST_TRUNC  = 2'd2
    } status_t;

    localparam logic [7:0] OP_RM_REG_LO  = 8'h88;
    localparam logic [7:0] OP_RM_REG_HI  = 8'h8B;
    localparam logic [7:0] OP_IMM_RM_LO  = 8'hC6;
    localparam logic [7:0] OP_IMM_RM_HI  = 8'hC7;
    localparam logic [7:0] OP_IMM_REG_LO = 8'hB0;
    localparam logic [7:0] OP_IMM_REG_HI = 8'hBF;
    localparam logic [7:0] OP_MEM_ACC_LO = 8'hA0;
    localparam logic [7:0] OP_MEM_ACC_HI = 8'hA1;
    localparam logic [7:0] OP_ACC_MEM_LO = 8'hA2;
    localparam logic [7:0] OP_ACC_MEM_HI = 8'hA3;

    localparam logic [1:0] MODE_NODISP = 2'b00;
    localparam logic [1:0] MODE_DISP8  = 2'b01;
    localparam logic [1:0] MODE_DISP16 = 2'b10;
    localparam logic [1:0] MODE_REG    = 2'b11;
    localparam logic [2:0] RM_DIRECT   = 3'b110;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        status_t     status;
        form_t       form;
        logic        wide;
        logic        dir;
        logic [1:0]  mode;
        logic [2:0]  reg_code;
        logic [2:0]  rm;
        logic [15:0] disp;
        logic [15:0] addr;
        logic [15:0] imm;
        logic [7:0]  bad;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> sv/movdec_ifs.sv
// Valid/ready channel interfaces for code bytes and decoded results.
// No dependencies.
interface movdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink (input valid, input code_byte, input stream_end, output ready);
endinterface

interface movdec_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               wide;
    logic [1:0]         dst_kind;
    logic [2:0]         dst_reg;
    logic [1:0]         src_kind;
    logic [2:0]         src_reg;
    logic [2:0]         ea_select;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [15:0]        direct_address;
    logic [7:0]         bad_opcode;

    modport source (
        output valid, output status, output wide, output dst_kind, output dst_reg,
        output src_kind, output src_reg, output ea_select, output displacement,
        output immediate, output direct_address, output bad_opcode, input ready
    );
    modport sink (
        input valid, input status, input wide, input dst_kind, input dst_reg,
        input src_kind, input src_reg, input ea_select, input displacement,
        input immediate, input direct_address, input bad_opcode, output ready
    );
endinterface

>>> sv/movdec_front.sv
// Front end: accepts code bytes, runs the phase machine and collects instruction fields.
// Depends on movdec_pkg and movdec_in_if; pushes one record per finished instruction.
module movdec_front (
    input  logic                clk,
    input  logic                rst_n,
    movdec_in_if.sink           code,
    input  movdec_pkg::q_stat_t q_stat,
    output logic                push,
    output movdec_pkg::rec_t    push_rec
);
    import movdec_pkg::*;

    phase_t      phase_reg, phase_next;
    form_t       form_reg, form_next;
    logic        wide_reg, wide_next;
    logic        dir_reg, dir_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  regc_reg, regc_next;
    logic [2:0]  rm_reg, rm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] imm_reg, imm_next;
    logic        accept;
    logic        bad_op;
    phase_t      ph_after;
    logic [7:0]  b;

    function automatic phase_t after_rm(form_t f);
        return (f == FORM_IMM_RM) ? PH_IMM_LO : PH_OPCODE;
    endfunction

    assign code.ready = !q_stat.full;
    assign accept     = code.valid && code.ready;
    assign b          = code.code_byte;

    always_comb
    begin
        form_next = form_reg;
        wide_next = wide_reg;
        dir_next  = dir_reg;
        mode_next = mode_reg;
        regc_next = regc_reg;
        rm_next   = rm_reg;
        disp_next = disp_reg;
        addr_next = addr_reg;
        imm_next  = imm_reg;
        bad_op    = 1'b0;
        ph_after  = PH_OPCODE;
        case (phase_reg)
            PH_MODRM:
            begin
                mode_next = b[7:6];
                regc_next = b[5:3];
                rm_next   = b[2:0];
                if (b[7:6] == MODE_NODISP && b[2:0] == RM_DIRECT)
                    ph_after = PH_ADDR_LO;
                else if (b[7:6] == MODE_DISP8 || b[7:6] == MODE_DISP16)
                    ph_after = PH_DISP_LO;
                else
                    ph_after = after_rm(form_reg);
            end
            PH_DISP_LO:
            begin
                if (mode_reg == MODE_DISP8)
                begin
                    disp_next = {{8{b[7]}}, b};
                    ph_after  = after_rm(form_reg);
                end
                else
                begin
                    disp_next = {8'h00, b};
                    ph_after  = PH_DISP_HI;
                end
            end
            PH_DISP_HI:
            begin
                disp_next = {b, disp_reg[7:0]};
                ph_after  = after_rm(form_reg);
            end
            PH_ADDR_LO:
            begin
                addr_next = {8'h00, b};
                ph_after  = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                addr_next = {b, addr_reg[7:0]};
                ph_after  = after_rm(form_reg);
            end
            PH_IMM_LO:
            begin
                imm_next = {8'h00, b};
                ph_after = wide_reg ? PH_IMM_HI : PH_OPCODE;
            end
            PH_IMM_HI:
            begin
                imm_next = {b, imm_reg[7:0]};
                ph_after = PH_OPCODE;
            end
            default:
            begin
                dir_next  = 1'b0;
                mode_next = 2'b00;
                regc_next = 3'b000;
                rm_next   = 3'b000;
                disp_next = 16'h0000;
                addr_next = 16'h0000;
                imm_next  = 16'h0000;
                if (b inside {[OP_RM_REG_LO:OP_RM_REG_HI]})
                begin
                    form_next = FORM_RM_REG;
                    wide_next = b[0];
                    dir_next  = b[1];
                    ph_after  = PH_MODRM;
                end
                else if (b inside {[OP_IMM_RM_LO:OP_IMM_RM_HI]})
                begin
                    form_next = FORM_IMM_RM;
                    wide_next = b[0];
                    ph_after  = PH_MODRM;
                end
                else if (b inside {[OP_IMM_REG_LO:OP_IMM_REG_HI]})
                begin
                    form_next = FORM_IMM_REG;
                    wide_next = b[3];
                    regc_next = b[2:0];
                    ph_after  = PH_IMM_LO;
                end
                else if (b inside {[OP_MEM_ACC_LO:OP_MEM_ACC_HI]})
                begin
                    form_next = FORM_MEM_ACC;
                    wide_next = b[0];
                    ph_after  = PH_ADDR_LO;
                end
                else if (b inside {[OP_ACC_MEM_LO:OP_ACC_MEM_HI]})
                begin
                    form_next = FORM_ACC_MEM;
                    wide_next = b[0];
                    ph_after  = PH_ADDR_LO;
                end
                else
                begin
                    form_next = FORM_RM_REG;
                    wide_next = 1'b0;
                    bad_op    = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        push_rec          = '0;
        push_rec.form     = form_next;
        push_rec.wide     = wide_next;
        push_rec.dir      = dir_next;
        push_rec.mode     = mode_next;
        push_rec.reg_code = regc_next;
        push_rec.rm       = rm_next;
        push_rec.disp     = disp_next;
        push_rec.addr     = addr_next;
        push_rec.imm      = imm_next;
        push_rec.status   = ST_OK;
        push              = 1'b0;
        phase_next        = ph_after;
        if (bad_op)
        begin
            push_rec        = '0;
            push_rec.status = ST_BAD_OP;
            push_rec.bad    = b;
            push            = accept;
            phase_next      = PH_OPCODE;
        end
        else if (ph_after == PH_OPCODE)
        begin
            push = accept;
        end
        else if (code.stream_end)
        begin
            push_rec        = '0;
            push_rec.status = ST_TRUNC;
            push            = accept;
            phase_next      = PH_OPCODE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            form_reg  <= FORM_RM_REG;
            wide_reg  <= 1'b0;
            dir_reg   <= 1'b0;
            mode_reg  <= 2'b00;
            regc_reg  <= 3'b000;
            rm_reg    <= 3'b000;
            disp_reg  <= 16'h0000;
            addr_reg  <= 16'h0000;
            imm_reg   <= 16'h0000;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            form_reg  <= form_next;
            wide_reg  <= wide_next;
            dir_reg   <= dir_next;
            mode_reg  <= mode_next;
            regc_reg  <= regc_next;
            rm_reg    <= rm_next;
            disp_reg  <= disp_next;
            addr_reg  <= addr_next;
            imm_reg   <= imm_next;
        end
    end

endmodule

>>> sv/movdec_queue.sv
// Short register queue carrying instruction records from the front end to the back end.
// Depends on movdec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module movdec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  movdec_pkg::rec_t    push_rec,
    input  logic                pop,
    output movdec_pkg::rec_t    head,
    output movdec_pkg::q_stat_t q_stat
);
    import movdec_pkg::*;

    rec_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    `MOVDEC_NEVER(a_no_push_full, push && q_stat.full, "queue pushed while full")
    `MOVDEC_NEVER(a_no_pop_empty, pop && q_stat.empty, "queue popped while empty")
    `MOVDEC_ASSERT(a_cnt_grows, push && !pop |=> cnt_reg == QCNT_W'($past(cnt_reg) + 1'b1), "queue count did not grow on push")
    `MOVDEC_NEVER(a_cnt_range, cnt_reg > QCNT_W'(QDEPTH), "queue count above depth")

endmodule

>>> sv/movdec_back.sv
// Back end: turns instruction records into operand descriptions and holds the result register.
// Depends on movdec_pkg and movdec_out_if.
module movdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  movdec_pkg::rec_t    head,
    input  movdec_pkg::q_stat_t q_stat,
    output logic                pop,
    movdec_out_if.source        result
);
    import movdec_pkg::*;

    logic               valid_reg;
    logic [1:0]         status_reg, status_next;
    logic               wide_reg, wide_next;
    kind_t              dk_reg, dk_next;
    logic [2:0]         dr_reg, dr_next;
    kind_t              sk_reg, sk_next;
    logic [2:0]         sr_reg, sr_next;
    logic [2:0]         ea_reg, ea_next;
    logic signed [15:0] disp_reg, disp_next;
    logic [15:0]        imm_reg, imm_next;
    logic [15:0]        addr_reg, addr_next;
    logic [7:0]         bad_reg, bad_next;
    kind_t              rk;
    logic [2:0]         rr;
    logic               uses_rm;

    assign pop = !q_stat.empty && (!valid_reg || result.ready);

    always_comb
    begin
        if (head.mode == MODE_REG)
        begin
            rk = KIND_REG;
            rr = head.rm;
        end
        else if (head.mode == MODE_NODISP && head.rm == RM_DIRECT)
        begin
            rk = KIND_DIR;
            rr = 3'b000;
        end
        else
        begin
            rk = KIND_EA;
            rr = 3'b000;
        end

        dk_next = KIND_REG;
        dr_next = 3'b000;
        sk_next = KIND_REG;
        sr_next = 3'b000;
        uses_rm = 1'b0;
        case (head.form)
            FORM_RM_REG:
            begin
                uses_rm = 1'b1;
                if (head.dir)
                begin
                    dr_next = head.reg_code;
                    sk_next = rk;
                    sr_next = rr;
                end
                else
                begin
                    sr_next = head.reg_code;
                    dk_next = rk;
                    dr_next = rr;
                end
            end
            FORM_IMM_RM:
            begin
                uses_rm = 1'b1;
                dk_next = rk;
                dr_next = rr;
                sk_next = KIND_IMM;
            end
            FORM_IMM_REG:
            begin
                dr_next = head.reg_code;
                sk_next = KIND_IMM;
            end
            FORM_MEM_ACC:
            begin
                sk_next = KIND_DIR;
            end
            default:
            begin
                dk_next = KIND_DIR;
            end
        endcase

        status_next = head.status;
        wide_next   = head.wide;
        bad_next    = head.bad;
        ea_next     = 3'b000;
        disp_next   = 16'sh0000;
        imm_next    = 16'h0000;
        addr_next   = 16'h0000;
        if (uses_rm && (dk_next == KIND_EA || sk_next == KIND_EA))
        begin
            ea_next   = head.rm;
            disp_next = $signed(head.disp);
        end
        if (sk_next == KIND_IMM)
            imm_next = head.imm;
        if (dk_next == KIND_DIR || sk_next == KIND_DIR)
            addr_next = head.addr;

        // Error results carry only the status and the offending opcode.
        if (head.status != ST_OK)
        begin
            wide_next = 1'b0;
            dk_next   = KIND_REG;
            dr_next   = 3'b000;
            sk_next   = KIND_REG;
            sr_next   = 3'b000;
            ea_next   = 3'b000;
            disp_next = 16'sh0000;
            imm_next  = 16'h0000;
            addr_next = 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            wide_reg   <= wide_next;
            dk_reg     <= dk_next;
            dr_reg     <= dr_next;
            sk_reg     <= sk_next;
            sr_reg     <= sr_next;
            ea_reg     <= ea_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
            addr_reg   <= addr_next;
            bad_reg    <= bad_next;
        end
    end

    assign result.valid          = valid_reg;
    assign result.status         = status_reg;
    assign result.wide           = wide_reg;
    assign result.dst_kind       = dk_reg;
    assign result.dst_reg        = dr_reg;
    assign result.src_kind       = sk_reg;
    assign result.src_reg        = sr_reg;
    assign result.ea_select      = ea_reg;
    assign result.displacement   = disp_reg;
    assign result.immediate      = imm_reg;
    assign result.direct_address = addr_reg;
    assign result.bad_opcode     = bad_reg;

endmodule

>>> sv/mov_instruction_byte_decoder_unit.sv
// Top level of the 8086 MOV byte decoder: front end, record queue and back end.
// Depends on movdec_pkg, movdec_ifs, movdec_front, movdec_queue and movdec_back.
//
//   Channel   Dir  Request                 Payload
//   code      in   one byte of code        code_byte, stream_end
//   result    out  one decoded instruction  status .. bad_opcode (11 fields)
//
// One code byte is taken per cycle while the queue is not full; the phase machine accepts a byte in every phase.
// A result passes through the record queue and then the result register after the byte that completes its instruction.
// Reset returns the phase machine to awaiting an opcode and empties the queue.
// A stalled result fills the two-entry queue; code bytes stall only once it is full.
module mov_instruction_byte_decoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    movdec_in_if.sink    code,
    movdec_out_if.source result
);
    import movdec_pkg::*;

    logic    push;
    rec_t    push_rec;
    logic    pop;
    rec_t    head;
    q_stat_t q_stat;

    movdec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .code     (code),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    movdec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    movdec_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

endmodule
